// ----- design/fqs_pkg.sv -----
// Package for the FIFO queue with statistics: command and status codes, and the
// controller-to-datapath command and status structures.
// No dependencies.
package fqs_pkg;

	// Default number of entries in the ring store.
	localparam int DEPTH_DEF = 64;

	// Width of a stored value and of the fixed-point mean.
	localparam int VAL_W  = 32;
	localparam int MEAN_W = 40;
	localparam int FRAC_W = 8;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_QUERY   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DEQ_RD,
		S_WALK,
		S_DIV,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic enq_write;
		logic set_full;
		logic set_empty;
		logic deq_read;
		logic deq_take;
		logic walk_init;
		logic walk_issue;
		logic div_start;
		logic res_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t command;
		logic full;
		logic empty;
		logic walk_issued;
		logic rd_vld;
		logic div_done;
	} dp_sts_t;

endpackage

// ----- design/fqs_div.sv -----
// Restoring unsigned divider that produces one quotient bit per cycle.
// Depends on nothing outside this file.
module fqs_div #(
	parameter int NW = 46,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW:0]      trial;
	logic             fits;

	// The numerator shifts out of the top of the quotient register while the
	// quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = (trial >= {1'b0, denom});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, denom});
			end else begin
				rem_q <= trial[DW-1:0];
			end
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- design/fqs_dpath.sv -----
// Datapath of the FIFO queue with statistics: ring store, pointers, the walk
// accumulators, the mean divider and the result register.
// Depends on fqs_pkg and fqs_div.
module fqs_dpath #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fqs_pkg::dp_cmd_t                     cmd,
	output fqs_pkg::dp_sts_t                     sts,
	input  logic [1:0]                           command,
	input  logic signed [fqs_pkg::VAL_W-1:0]     value,
	output logic [1:0]                           status,
	output logic signed [fqs_pkg::VAL_W-1:0]     removed_value,
	output logic signed [fqs_pkg::VAL_W-1:0]     largest,
	output logic signed [fqs_pkg::VAL_W-1:0]     smallest,
	output logic signed [fqs_pkg::MEAN_W-1:0]    mean_q8,
	output logic [CW-1:0]                        occupancy
);

	localparam int VW   = fqs_pkg::VAL_W;
	localparam int MW   = fqs_pkg::MEAN_W;
	localparam int SUMW = VW + AW;
	localparam int NW   = SUMW + fqs_pkg::FRAC_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [VW-1:0] mem [DEPTH];

	fqs_pkg::cmd_t    cmd_q;
	logic [VW-1:0]    val_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    walk_ptr_q;
	logic [CW-1:0]    issued_q;
	logic             first_q;
	logic             rd_vld_s1;
	logic [VW-1:0]    rd_data_s1;
	logic signed [SUMW-1:0] sum_q;
	logic signed [VW-1:0]   mx_q;
	logic signed [VW-1:0]   mn_q;
	logic             neg_q;
	fqs_pkg::status_t status_q;
	logic [VW-1:0]    removed_q;
	logic [MW-1:0]    mean_q;

	fqs_pkg::status_t res_status_q;
	logic [VW-1:0]    res_removed_q;
	logic [VW-1:0]    res_large_q;
	logic [VW-1:0]    res_small_q;
	logic [MW-1:0]    res_mean_q;
	logic [CW-1:0]    res_occ_q;

	logic [AW-1:0]    rd_addr;
	logic             rd_en;
	logic signed [VW-1:0]   rd_val;
	logic [SUMW-1:0]  sum_mag;
	logic             div_done;
	logic [NW-1:0]    div_quot;
	logic [MW-1:0]    quot_trunc;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	assign rd_en   = cmd.deq_read | cmd.walk_issue;
	assign rd_addr = cmd.deq_read ? head_q : walk_ptr_q;
	assign rd_val  = $signed(rd_data_s1);
	assign sum_mag = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign quot_trunc = div_quot[MW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.enq_write) begin
			mem[tail_q] <= val_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Control state: queue pointers, occupancy and the read-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.walk_issue;
			if (cmd.enq_write) begin
				tail_q  <= next_idx(tail_q);
				count_q <= count_q + CW'(1);
			end
			if (cmd.deq_read) begin
				head_q  <= next_idx(head_q);
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Working registers for the transaction in flight.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= fqs_pkg::cmd_t'(command);
			val_q     <= value;
			status_q  <= fqs_pkg::ST_OK;
			removed_q <= '0;
			mx_q      <= '0;
			mn_q      <= '0;
			mean_q    <= '0;
		end
		if (cmd.set_full) begin
			status_q <= fqs_pkg::ST_FULL;
		end
		if (cmd.set_empty) begin
			status_q <= fqs_pkg::ST_EMPTY;
		end
		if (cmd.deq_take) begin
			removed_q <= rd_data_s1;
		end
		if (cmd.walk_init) begin
			walk_ptr_q <= head_q;
			issued_q   <= '0;
			first_q    <= 1'b1;
			sum_q      <= '0;
		end
		if (cmd.walk_issue) begin
			walk_ptr_q <= next_idx(walk_ptr_q);
			issued_q   <= issued_q + CW'(1);
		end
		if (rd_vld_s1) begin
			first_q <= 1'b0;
			sum_q   <= sum_q + SUMW'(rd_val);
			if (first_q || rd_val > mx_q) begin
				mx_q <= rd_val;
			end
			if (first_q || rd_val < mn_q) begin
				mn_q <= rd_val;
			end
		end
		if (cmd.div_start) begin
			neg_q <= sum_q[SUMW-1];
		end
		if (div_done) begin
			mean_q <= neg_q ? MW'(-quot_trunc) : quot_trunc;
		end
	end

	// Result register; it holds while the downstream side stalls.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q  <= status_q;
			res_removed_q <= removed_q;
			res_large_q   <= mx_q;
			res_small_q   <= mn_q;
			res_mean_q    <= mean_q;
			res_occ_q     <= count_q;
		end
	end

	fqs_div #(
		.NW(NW),
		.DW(CW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.numer ({sum_mag, fqs_pkg::FRAC_W'(0)}),
		.denom (count_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		sts.command     = cmd_q;
		sts.full        = (count_q == CW'(DEPTH));
		sts.empty       = (count_q == '0);
		sts.walk_issued = (issued_q == count_q);
		sts.rd_vld      = rd_vld_s1;
		sts.div_done    = div_done;
	end

	assign status        = res_status_q;
	assign removed_value = $signed(res_removed_q);
	assign largest       = $signed(res_large_q);
	assign smallest      = $signed(res_small_q);
	assign mean_q8       = $signed(res_mean_q);
	assign occupancy     = res_occ_q;

endmodule

// ----- design/fqs_ctrl.sv -----
// Controller of the FIFO queue with statistics: sequences each transaction and
// owns the handshake on both channels.
// Depends on fqs_pkg.
module fqs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	output logic             res_valid,
	input  logic             res_stall,
	input  fqs_pkg::dp_sts_t sts,
	output fqs_pkg::dp_cmd_t cmd
);

	fqs_pkg::state_t state_q;
	fqs_pkg::state_t state_d;
	logic            res_valid_q;
	logic            out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqs_pkg::S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd_stall = 1'b1;
		unique case (state_q)
			fqs_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					cmd.capture = 1'b1;
					state_d     = fqs_pkg::S_DECODE;
				end
			end
			fqs_pkg::S_DECODE: begin
				state_d = fqs_pkg::S_FINISH;
				unique case (sts.command)
					fqs_pkg::CMD_ENQUEUE: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
						end else begin
							cmd.enq_write = 1'b1;
						end
					end
					fqs_pkg::CMD_DEQUEUE: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
						end else begin
							cmd.deq_read = 1'b1;
							state_d      = fqs_pkg::S_DEQ_RD;
						end
					end
					fqs_pkg::CMD_QUERY: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
						end else begin
							cmd.walk_init = 1'b1;
							state_d       = fqs_pkg::S_WALK;
						end
					end
					default: begin
						state_d = fqs_pkg::S_FINISH;
					end
				endcase
			end
			fqs_pkg::S_DEQ_RD: begin
				cmd.deq_take = 1'b1;
				state_d      = fqs_pkg::S_FINISH;
			end
			fqs_pkg::S_WALK: begin
				cmd.walk_issue = !sts.walk_issued;
				if (sts.walk_issued && !sts.rd_vld) begin
					cmd.div_start = 1'b1;
					state_d       = fqs_pkg::S_DIV;
				end
			end
			fqs_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_d = fqs_pkg::S_FINISH;
				end
			end
			fqs_pkg::S_FINISH: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = fqs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fqs_pkg::S_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

// ----- design/fifo_queue_with_min_max_mean_top.sv -----
// Top level of the FIFO queue with statistics.
// Depends on fqs_pkg, fqs_ctrl and fqs_dpath.
//
// This block is a bounded first-in first-out queue of DEPTH signed 32-bit
// values. Every transaction on the command channel is an enqueue, a dequeue or
// a statistics query, and produces exactly one transaction on the result
// channel. Transactions are handled one at a time. An enqueue, a rejected
// command or an unused command code passes from acceptance through S_DECODE
// and S_FINISH to the result, and a dequeue also passes through S_DEQ_RD,
// because the ring store has one registered read port. A query on a non-empty
// queue reads the held values one per cycle through that same read port and
// then runs a restoring divider that makes one quotient bit per cycle over the
// 40 + log2(DEPTH) bit numerator. A finished result sits in an output
// register, so the next command is accepted while that result is still
// stalled; the block only waits when a new result is ready and the previous
// one has not yet been taken. The mean is the sum times 256 divided by the
// count, truncated toward zero. The occupancy output is the number of values
// held after the transaction. The ring store needs no clearing after reset,
// since only live entries are ever read.
module fifo_queue_with_min_max_mean_top #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Command channel.
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  logic [1:0]                           command,
	input  logic signed [fqs_pkg::VAL_W-1:0]     value,
	// Result channel.
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [1:0]                           status,
	output logic signed [fqs_pkg::VAL_W-1:0]     removed_value,
	output logic signed [fqs_pkg::VAL_W-1:0]     largest,
	output logic signed [fqs_pkg::VAL_W-1:0]     smallest,
	output logic signed [fqs_pkg::MEAN_W-1:0]    mean_q8,
	output logic [$clog2(DEPTH+1)-1:0]           occupancy
);

	// Control and status between the sequencer and the datapath.
	fqs_pkg::dp_cmd_t dp_cmd;
	fqs_pkg::dp_sts_t dp_sts;

	// The controller walks each transaction through its steps and owns the
	// valid flag of the result register.
	fqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// The datapath holds the ring store, the pointers, the statistics
	// accumulators, the divider and the result payload.
	fqs_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.sts          (dp_sts),
		.command      (command),
		.value        (value),
		.status       (status),
		.removed_value(removed_value),
		.largest      (largest),
		.smallest     (smallest),
		.mean_q8      (mean_q8),
		.occupancy    (occupancy)
	);

endmodule

// ----- test/tb_top.sv -----
// Testbench for fifo_queue_with_min_max_mean_top: a self-checking run of enqueue, dequeue
// and statistics query transactions with random idling on both channels.
// Depends on fqs_pkg and the block's RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int OCC_W = $clog2(DEPTH + 1);
	// Random items to send after the directed part.
	localparam int RANDOM_ITEMS = 428;
	// The limit covers a query on a full queue plus the longest sender gap and
	// receiver stall, with a wide margin on top.
	localparam int IDLE_LIMIT = 2000;
	// Cycles to keep watching after the last expected result has arrived.
	localparam int DRAIN_CYCLES = 150;

	localparam logic signed [fqs_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [fqs_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	// The one command code that the block leaves unused.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// One result transaction, in the order of the result ports.
	typedef struct packed {
		fqs_pkg::status_t                  status;
		logic signed [fqs_pkg::VAL_W-1:0]  removed_value;
		logic signed [fqs_pkg::VAL_W-1:0]  largest;
		logic signed [fqs_pkg::VAL_W-1:0]  smallest;
		logic signed [fqs_pkg::MEAN_W-1:0] mean_q8;
		logic [OCC_W-1:0]                  occupancy;
	} queue_result_t;

	// The scoreboard keeps its own copy of the ring, works out the result of
	// every accepted command, and compares the results in arrival order.
	class fifo_stats_checker;
		logic signed [fqs_pkg::VAL_W-1:0] ring [DEPTH];
		int unsigned             head;
		int unsigned             tail;
		int unsigned             held;
		queue_result_t           expected_results [$];
		int                      errors;

		function new();
			head = 0;
			tail = 0;
			held = 0;
			errors = 0;
		endfunction

		function void report(string what);
			errors++;
			if (errors <= 10) begin
				$display("%0t ns: mismatch: %s", $realtime, what);
			end
		endfunction

		// Works out the result of one accepted command and updates the ring.
		function void note_command(logic [1:0] cmd, logic signed [fqs_pkg::VAL_W-1:0] val);
			queue_result_t                    exp_res;
			logic signed [fqs_pkg::VAL_W-1:0] hi;
			logic signed [fqs_pkg::VAL_W-1:0] lo;
			logic signed [fqs_pkg::VAL_W-1:0] v;
			longint                           sum;
			longint                           quot;
			int unsigned                      idx;
			exp_res = '0;
			exp_res.status = fqs_pkg::ST_OK;
			case (cmd)
				fqs_pkg::CMD_ENQUEUE: begin
					if (held >= DEPTH) begin
						exp_res.status = fqs_pkg::ST_FULL;
					end else begin
						ring[tail] = val;
						tail = (tail + 1) % DEPTH;
						held++;
					end
				end
				fqs_pkg::CMD_DEQUEUE: begin
					if (held == 0) begin
						exp_res.status = fqs_pkg::ST_EMPTY;
					end else begin
						exp_res.removed_value = ring[head];
						head = (head + 1) % DEPTH;
						held--;
					end
				end
				fqs_pkg::CMD_QUERY: begin
					if (held == 0) begin
						exp_res.status = fqs_pkg::ST_EMPTY;
					end else begin
						idx = head;
						hi = ring[idx];
						lo = hi;
						sum = 0;
						for (int k = 0; k < held; k++) begin
							v = ring[idx];
							if (v > hi) hi = v;
							if (v < lo) lo = v;
							sum += v;
							idx = (idx + 1) % DEPTH;
						end
						// Signed division truncates toward zero, as the mean must.
						quot = (sum * 256) / longint'(held);
						exp_res.largest = hi;
						exp_res.smallest = lo;
						exp_res.mean_q8 = quot[fqs_pkg::MEAN_W-1:0];
					end
				end
				default: begin
				end
			endcase
			exp_res.occupancy = OCC_W'(held);
			expected_results.push_back(exp_res);
		endfunction

		function void check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
			if (exp_val !== got_val) begin
				report($sformatf("%s expected %h, got %h", name, exp_val, got_val));
			end
		endfunction

		function void check_result(queue_result_t got);
			queue_result_t exp_res;
			if (expected_results.size() == 0) begin
				report("result transaction with no command waiting for it");
				return;
			end
			exp_res = expected_results.pop_front();
			check_field("status", 64'(exp_res.status), 64'(got.status));
			check_field("removed_value", 64'(exp_res.removed_value), 64'(got.removed_value));
			check_field("largest", 64'(exp_res.largest), 64'(got.largest));
			check_field("smallest", 64'(exp_res.smallest), 64'(got.smallest));
			check_field("mean_q8", 64'(exp_res.mean_q8), 64'(got.mean_q8));
			check_field("occupancy", 64'(exp_res.occupancy), 64'(got.occupancy));
		endfunction

		function int waiting();
			return expected_results.size();
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cmd_valid = 1'b0;
	logic                              cmd_stall;
	logic [1:0]                        command = 2'd0;
	logic signed [fqs_pkg::VAL_W-1:0]  value = '0;
	logic                              res_valid;
	logic                              res_stall = 1'b0;
	logic [1:0]                        status;
	logic signed [fqs_pkg::VAL_W-1:0]  removed_value;
	logic signed [fqs_pkg::VAL_W-1:0]  largest;
	logic signed [fqs_pkg::VAL_W-1:0]  smallest;
	logic signed [fqs_pkg::MEAN_W-1:0] mean_q8;
	logic [OCC_W-1:0]                  occupancy;

	fifo_stats_checker sb;

	// When set, neither side idles, so transactions run back to back.
	bit  quiet = 1'b0;
	int  stall_left = 0;
	int  idle_cycles = 0;

	fifo_queue_with_min_max_mean_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.value(value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.removed_value(removed_value),
		.largest(largest),
		.smallest(smallest),
		.mean_q8(mean_q8),
		.occupancy(occupancy)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Values lean toward the extremes and small numbers near zero, where the
	// min, max and rounding of the mean are easiest to get wrong. A run style
	// of 1 or 2 fills the queue with the largest or smallest value, so the
	// sum and mean reach their limits.
	function automatic logic signed [fqs_pkg::VAL_W-1:0] pick_value(int style);
		if (style == 1) return VAL_MAX;
		if (style == 2) return VAL_MIN;
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3: return $signed($urandom_range(0, 20)) - 10;
			default: return $urandom();
		endcase
	endfunction

	// The receiver stalls in bursts of random length. The stall is driven at
	// the clock edge, so it never changes in the middle of a cycle.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 30) begin
			stall_left <= pick_gap();
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// A result transaction completes at an edge where valid is high and the
	// stall is low; both are sampled as they stood just before the edge.
	always @(posedge clk) begin
		queue_result_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.status = fqs_pkg::status_t'(status);
			got.removed_value = removed_value;
			got.largest = largest;
			got.smallest = smallest;
			got.mean_q8 = mean_q8;
			got.occupancy = occupancy;
			sb.check_result(got);
		end
	end

	// The watchdog ends a run in which no transaction completes on either
	// channel for too long, which would mean the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Sends one command transaction after an optional gap. Valid stays high
	// from one transaction to the next when there is no gap, so it gets a
	// single assignment in each time step. The payload holds while stalled.
	task automatic send_command(logic [1:0] cmd, logic signed [fqs_pkg::VAL_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		value <= val;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(cmd, val);
	endtask

	// Holds the sender back until every expected result has come out.
	task automatic wait_until_drained();
		cmd_valid <= 1'b0;
		while (sb.waiting() != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int phase;
		int phase_len;
		int enq_pct;
		int deq_pct;
		int style;
		int r;
		logic [1:0] cmd;

		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the empty queue, the unused command code, the value
		// extremes, a mean that must truncate toward zero, and a queue drained
		// back to empty.
		send_command(fqs_pkg::CMD_QUERY, VAL_MAX);
		send_command(fqs_pkg::CMD_DEQUEUE, VAL_MIN);
		send_command(CMD_UNUSED, -1);
		send_command(fqs_pkg::CMD_ENQUEUE, VAL_MAX);
		send_command(fqs_pkg::CMD_ENQUEUE, VAL_MIN);
		send_command(fqs_pkg::CMD_ENQUEUE, 0);
		send_command(fqs_pkg::CMD_ENQUEUE, -1);
		send_command(fqs_pkg::CMD_ENQUEUE, 1);
		send_command(fqs_pkg::CMD_QUERY, 0);
		send_command(CMD_UNUSED, VAL_MIN);
		send_command(fqs_pkg::CMD_DEQUEUE, 0);
		send_command(fqs_pkg::CMD_DEQUEUE, 0);
		send_command(fqs_pkg::CMD_QUERY, 0);
		send_command(fqs_pkg::CMD_DEQUEUE, 0);
		send_command(fqs_pkg::CMD_DEQUEUE, 0);
		send_command(fqs_pkg::CMD_DEQUEUE, 0);
		send_command(fqs_pkg::CMD_DEQUEUE, 0);
		send_command(fqs_pkg::CMD_QUERY, 0);
		// Sum of -1 over a count of 3: the mean is -85.33 and must read -85.
		send_command(fqs_pkg::CMD_ENQUEUE, -1);
		send_command(fqs_pkg::CMD_ENQUEUE, 0);
		send_command(fqs_pkg::CMD_ENQUEUE, 0);
		send_command(fqs_pkg::CMD_QUERY, 0);
		wait_until_drained();

		// Random part in phases. Fill phases push the queue up to full and
		// into rejected enqueues, drain phases take it down to empty and past
		// it, and balanced phases wander in between. Queries are spread over
		// all of them so that the statistics see every occupancy.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(50, 100);
			case (phase % 3)
				0: begin
					enq_pct = 75;
					deq_pct = 7;
				end
				1: begin
					enq_pct = 41;
					deq_pct = 41;
				end
				default: begin
					enq_pct = 15;
					deq_pct = 67;
				end
			endcase
			r = $urandom_range(0, 9);
			style = (r == 0) ? 1 : (r == 1) ? 2 : 0;
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < enq_pct) cmd = fqs_pkg::CMD_ENQUEUE;
				else if (r < enq_pct + deq_pct) cmd = fqs_pkg::CMD_DEQUEUE;
				else if (r < 97) cmd = fqs_pkg::CMD_QUERY;
				else cmd = CMD_UNUSED;
				send_command(cmd, pick_value(style));
				sent++;
			end
			if ($urandom_range(0, 2) == 0) begin
				wait_until_drained();
			end
			phase++;
		end
		quiet = 1'b0;
		cmd_valid <= 1'b0;

		// Wait for the last results, then watch a while longer for any result
		// that should not come.
		while (sb.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.waiting() != 0) begin
			sb.report("expected results left over at the end");
		end
		if (sb.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
